// ===== hdl/positional_list_insert_delete_macros.svh =====
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked on clock, off during reset.
`define PLID_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off during reset.
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/plid_pkg.sv =====
// Package: field widths, request and status codes, cell select type.
`timescale 1ns / 1ps

package plid_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int REQ_TYPE_W = 2;
   localparam int POSITION_W = 5;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_LOAD,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_HEAD
   } plid_cell_sel_type;

endpackage

// ===== hdl/plid_if.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface plid_req_if;
   import plid_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [REQ_TYPE_W-1:0]        req_type;
   logic [POSITION_W-1:0]        position;
   logic signed [VALUE_W-1:0]    value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface plid_rsp_if;
   import plid_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic [COUNT_W-1:0]           count;
   logic                         has_value;
   logic signed [VALUE_W-1:0]    value_res;
   logic                         last;

   modport source (output valid, status, count, has_value, value_res, last, input ready);
   modport sink   (input valid, status, count, has_value, value_res, last, output ready);
endinterface

// ===== hdl/plid_cell.sv =====
// One list cell: holds an entry, takes a new word, a neighbor's word or the head cell's word.
`timescale 1ns / 1ps

module plid_cell #(
   parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  plid_pkg::plid_cell_sel_type sel,
   input  logic [DATA_WIDTH-1:0]       load_word,
   input  logic [DATA_WIDTH-1:0]       left_word,
   input  logic [DATA_WIDTH-1:0]       right_word,
   input  logic [DATA_WIDTH-1:0]       head_word,
   output logic [DATA_WIDTH-1:0]       word
);
   import plid_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      case (sel)
         SEL_LOAD:  word_in = load_word;
         SEL_LEFT:  word_in = left_word;
         SEL_RIGHT: word_in = right_word;
         SEL_HEAD:  word_in = head_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// Positional list top level: a chain of cells with a request decoder and output register.
// Insert, delete and unknown codes: one response, registered, the cycle after acceptance;
// one request per cycle while the response is taken.
// Dump of N entries: N responses, registered from the head cell once the state enters dump,
// one per cycle while taken, the chain turning by one place; an empty dump gives one response.
// Synchronous reset empties the list and clears the state and response valid.
`timescale 1ns / 1ps
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete #(
   parameter int CAPACITY   = plid_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   plid_req_if.sink    req_chan,
   plid_rsp_if.source  rsp_chan
);
   import plid_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } plid_state_type;

   plid_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        dump_left_ff, dump_left_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_has_value_ff, rsp_has_value_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    out_free;
   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic                    ins_bad_pos;
   logic                    del_bad_pos;
   logic                    list_full;
   logic [IDX_W-1:0]        pos_idx;
   logic                    ins_ok;
   logic                    del_ok;
   logic                    dump_emit;
   logic [DATA_WIDTH-1:0]   load_word;

   logic [DATA_WIDTH-1:0]   word     [CAPACITY];
   plid_cell_sel_type       cell_sel [CAPACITY];

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext     = CMP_W'(req_chan.position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign ins_bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + 1'b1);
   assign del_bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign list_full   = (count_ff == CNT_W'(CAPACITY));
   assign pos_idx     = IDX_W'(pos_ext - 1'b1);

   assign ins_ok    = accept && (req_chan.req_type == REQ_INSERT) && !ins_bad_pos && !list_full;
   assign del_ok    = accept && (req_chan.req_type == REQ_DELETE) && !del_bad_pos;
   assign dump_emit = (state_ff == ST_DUMP) && out_free;

   assign load_word = DATA_WIDTH'(64'($unsigned(req_chan.value)));

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam bit HAS_RIGHT = (g < CAPACITY - 1);
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;

      if (g == 0) begin : g_left_edge
         assign left_word = word[0];
      end else begin : g_left
         assign left_word = word[g-1];
      end

      if (HAS_RIGHT) begin : g_right
         assign right_word = word[g+1];
      end else begin : g_right_edge
         assign right_word = word[g];
      end

      always_comb begin
         cell_sel[g] = SEL_HOLD;
         if (ins_ok) begin
            if (IDX_W'(g) > pos_idx) begin
               cell_sel[g] = SEL_LEFT;
            end else if (IDX_W'(g) == pos_idx) begin
               cell_sel[g] = SEL_LOAD;
            end
         end else if (del_ok) begin
            if (HAS_RIGHT && (IDX_W'(g) >= pos_idx)) begin
               cell_sel[g] = SEL_RIGHT;
            end
         end else if (dump_emit) begin
            if (CNT_W'(g + 1) == count_ff) begin
               cell_sel[g] = SEL_HEAD;
            end else if (CNT_W'(g + 1) < count_ff) begin
               cell_sel[g] = SEL_RIGHT;
            end
         end
      end

      plid_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .sel        (cell_sel[g]),
         .load_word  (load_word),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (word[0]),
         .word       (word[g])
      );
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      dump_left_in     = dump_left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_has_value_in = rsp_has_value_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_last_in      = rsp_last_ff;

      if (accept) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = STATUS_OK;
         rsp_has_value_in = 1'b0;
         rsp_value_in     = '0;
         rsp_last_in      = 1'b1;
         case (req_chan.req_type)
            REQ_INSERT: begin
               if (ins_bad_pos) begin
                  rsp_status_in = STATUS_RANGE;
               end else if (list_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_DELETE: begin
               if (del_bad_pos) begin
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_DUMP: begin
               if (count_ff != '0) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_DUMP;
                  dump_left_in = count_ff;
               end
            end
            default: begin
            end
         endcase
         rsp_count_in = COUNT_W'(count_in);
      end else if (dump_emit) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = STATUS_OK;
         rsp_count_in     = COUNT_W'(count_ff);
         rsp_has_value_in = 1'b1;
         rsp_value_in     = VALUE_W'(64'($signed(word[0])));
         rsp_last_in      = (dump_left_ff == CNT_W'(1));
         dump_left_in     = dump_left_ff - 1'b1;
         if (dump_left_ff == CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_has_value_ff <= rsp_has_value_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.has_value = rsp_has_value_ff;
   assign rsp_chan.value_res = $signed(rsp_value_ff);
   assign rsp_chan.last      = rsp_last_ff;

   `PLID_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `PLID_ASSERT_NEXT(a_insert_grows, ins_ok, count_ff == CNT_W'($past(count_ff) + 1'b1), "insert did not grow list")
   `PLID_ASSERT_NEXT(a_delete_shrinks, del_ok, count_ff == CNT_W'($past(count_ff) - 1'b1), "delete did not shrink list")
   `PLID_ASSERT_NOW(a_nonlast_in_dump, rsp_chan.valid && !rsp_chan.last, state_ff == ST_DUMP, "non-final response outside dump")

endmodule

// ===== tb/plid_list_checker.sv =====
// Checker for the positional list: predicts each request's responses and compares them.
`timescale 1ns / 1ps

module plid_list_checker (
   input  logic clock,
   input  logic reset,
   plid_req_if  req_mon,
   plid_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   list_len,
   output int   replies_checked,
   output int   rejects_seen
);
   import plid_pkg::*;

   localparam int LIST_DEPTH = CAPACITY_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                has_value;
      logic [VALUE_W-1:0]  value_res;
      logic                last;
   } list_reply_type;

   logic [VALUE_W-1:0] cells [LIST_DEPTH];
   list_reply_type pending_replies [$];

   task automatic push_reply(input logic [STATUS_W-1:0] st, input logic has,
                             input logic [VALUE_W-1:0] word, input logic fin);
      list_reply_type r;
      r.status    = st;
      r.count     = list_len[COUNT_W-1:0];
      r.has_value = has;
      r.value_res = has ? word : '0;
      r.last      = fin;
      if (st != STATUS_OK) rejects_seen++;
      pending_replies.push_back(r);
   endtask

   task automatic apply_list_request(input logic [REQ_TYPE_W-1:0] kind,
                                     input logic [POSITION_W-1:0] pos_in,
                                     input logic [VALUE_W-1:0] word);
      int pos;
      int i;
      pos = int'(pos_in);
      case (kind)
         REQ_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               push_reply(STATUS_RANGE, 1'b0, '0, 1'b1);
            end else if (list_len >= LIST_DEPTH) begin
               push_reply(STATUS_FULL, 1'b0, '0, 1'b1);
            end else begin
               for (i = list_len; i >= pos; i--) cells[i] = cells[i-1];
               cells[pos-1] = word;
               list_len++;
               push_reply(STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         REQ_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               push_reply(STATUS_RANGE, 1'b0, '0, 1'b1);
            end else begin
               for (i = pos; i < list_len; i++) cells[i-1] = cells[i];
               list_len--;
               push_reply(STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (list_len == 0) begin
               push_reply(STATUS_OK, 1'b0, '0, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++)
                  push_reply(STATUS_OK, 1'b1, cells[i], i == list_len - 1);
            end
         end
         default: begin
            push_reply(STATUS_OK, 1'b0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic field_check(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_reply();
      list_reply_type want;
      if (pending_replies.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                  $time, rsp_mon.status, rsp_mon.count);
      end else begin
         want = pending_replies.pop_front();
         replies_checked++;
         field_check("status", want.status, rsp_mon.status);
         field_check("count", want.count, rsp_mon.count);
         field_check("has_value", want.has_value, rsp_mon.has_value);
         field_check("value_res", want.value_res, rsp_mon.value_res);
         field_check("last", want.last, rsp_mon.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         pending_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_reply();
         if (req_mon.valid && req_mon.ready)
            apply_list_request(req_mon.req_type, req_mon.position, req_mon.value);
      end
      outstanding = pending_replies.size();
   end

endmodule

// ===== tb/tb_positional_list_insert_delete.sv =====
// Testbench top for the positional list: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete;
   import plid_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int LIST_DEPTH      = CAPACITY_DEF;
   localparam int RANDOM_REQUESTS = 320;
   localparam int CYCLE_LIMIT     = 400000;

   localparam int SEG_FILL  = 0;
   localparam int SEG_DRAIN = 1;
   localparam int SEG_CHURN = 2;

   logic clock;
   logic reset;

   plid_req_if req_bus ();
   plid_rsp_if rsp_bus ();

   int mismatches;
   int outstanding;
   int list_len;
   int replies_checked;
   int rejects_seen;
   int cycle_count;
   int sent;
   int burst_left;
   int target;
   int seg;
   bit first_seg;
   bit [7:0] stall_phase;

   positional_list_insert_delete uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   plid_list_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .list_len        (list_len),
      .replies_checked (replies_checked),
      .rejects_seen    (rejects_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response stall pattern: free, light random, periodic, heavy random
   initial begin
      rsp_bus.ready = 1'b0;
      stall_phase = '0;
      forever begin
         @(negedge clock);
         stall_phase++;
         case (stall_phase[7:6])
            2'd0: rsp_bus.ready = 1'b1;
            2'd1: rsp_bus.ready = ($urandom_range(0, 99) >= 30);
            2'd2: rsp_bus.ready = (stall_phase[1:0] != 2'd0);
            default: rsp_bus.ready = ($urandom_range(0, 99) >= 75);
         endcase
      end
   end

   function automatic logic [VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      end
   endtask

   // called at a falling edge; returns at a falling edge after acceptance and any pacing gap
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input int pos,
                               input logic [VALUE_W-1:0] word);
      req_bus.valid    = 1'b1;
      req_bus.req_type = kind;
      req_bus.position = pos[POSITION_W-1:0];
      req_bus.value    = word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
      pace();
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic churn_one();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_request(REQ_INSERT, $urandom_range(1, list_len + 1), pick_word());
      end else if (r < 80) begin
         if (list_len > 0)
            send_request(REQ_DELETE, $urandom_range(1, list_len), pick_word());
         else
            send_request(REQ_DELETE, $urandom_range(0, 31), pick_word());
      end else if (r < 88) begin
         send_request(REQ_DUMP, $urandom_range(0, 31), pick_word());
      end else if (r < 94) begin
         send_request($urandom_range(0, 1) ? REQ_INSERT : REQ_DELETE,
                      $urandom_range(0, 1) ? 0 : $urandom_range(list_len + 2, 31),
                      pick_word());
      end else begin
         send_request(REQ_UNUSED, $urandom_range(0, 31), $urandom);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_INSERT;
      req_bus.position = '0;
      req_bus.value    = '0;
      sent       = 0;
      burst_left = 4;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, ends, middle, range rejects, unused code
      send_request(REQ_DUMP, 0, '0);
      send_request(REQ_DELETE, 1, '0);
      send_request(REQ_INSERT, 0, 32'h1234_5678);
      send_request(REQ_INSERT, 2, 32'h1234_5678);
      send_request(REQ_INSERT, 1, 32'h8000_0000);
      send_request(REQ_INSERT, 2, 32'h7fff_ffff);
      send_request(REQ_INSERT, 1, 32'hffff_ffff);
      send_request(REQ_INSERT, 2, 32'h0000_0000);
      send_request(REQ_INSERT, 5, 32'h5555_aaaa);
      send_request(REQ_INSERT, 31, 32'haaaa_5555);
      send_request(REQ_DUMP, 31, 32'hffff_ffff);
      send_request(REQ_DELETE, 0, '0);
      send_request(REQ_DELETE, 6, '0);
      send_request(REQ_DELETE, 31, '0);
      send_request(REQ_DELETE, 2, '0);
      send_request(REQ_DELETE, 1, '0);
      send_request(REQ_DELETE, 3, '0);
      send_request(REQ_UNUSED, 31, 32'hffff_ffff);
      send_request(REQ_DUMP, 0, '0);
      wait_drained();

      target    = sent + RANDOM_REQUESTS;
      first_seg = 1'b1;
      while (sent < target) begin
         if (first_seg) seg = SEG_FILL;
         else seg = ($urandom_range(0, 3) < 2) ? SEG_CHURN : $urandom_range(0, 1);
         first_seg = 1'b0;
         case (seg)
            SEG_FILL: begin
               while (list_len < LIST_DEPTH)
                  send_request(REQ_INSERT, $urandom_range(1, list_len + 1), pick_word());
               send_request(REQ_INSERT, $urandom_range(1, LIST_DEPTH + 1), pick_word());
               send_request(REQ_INSERT, $urandom_range(LIST_DEPTH + 2, 31), pick_word());
               send_request(REQ_DUMP, $urandom_range(0, 31), pick_word());
            end
            SEG_DRAIN: begin
               while (list_len > 0)
                  send_request(REQ_DELETE, $urandom_range(1, list_len), pick_word());
               send_request(REQ_DELETE, $urandom_range(0, 31), pick_word());
               send_request(REQ_DUMP, $urandom_range(0, 31), pick_word());
            end
            default: begin
               repeat ($urandom_range(10, 40)) churn_one();
            end
         endcase
         if ($urandom_range(0, 3) == 0) wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses, %0d of them rejects.",
               sent, replies_checked, rejects_seen);
      $display("Covered fill to capacity, full and range rejects, drains and dumps.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
